/* hdl/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// Command codes, wildcard byte values and the step/result bundles passed
// between the stream wrapper and the position-set core.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // Default pattern store capacity in bytes
  localparam int MAX_PATTERN_DEF = 32;

  // Wildcard and separator bytes
  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'

  // Command carried with every input word
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_END     = 2'd3
  } cmd_e_t;

  // One command applied to the core state
  typedef struct packed {
    logic       en;
    cmd_e_t     cmd;
    logic [7:0] character;
  } wpm_step_t;

  // End-of-subject report
  typedef struct packed {
    logic pattern_overflow;
    logic matched;
  } wpm_result_t;

endpackage

/* hdl/wpm_core.sv */
// ----------------------------------------------------------------------------
// wpm_core: pattern store and active position set
// Holds the pattern bytes, length and overflow flag, and advances the set
// of reachable pattern positions by one subject byte per cycle while a subject
// step is enabled. Star closure is computed as a single carry chain.
// ----------------------------------------------------------------------------
module wpm_core #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wpm_pkg::wpm_step_t  step,
  output wpm_pkg::wpm_result_t result
);
  import wpm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [MAX_PATTERN:0] ACT_INIT = {{MAX_PATTERN{1'b0}}, 1'b1};
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

  logic [7:0]             store_r [MAX_PATTERN];
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [MAX_PATTERN:0]   act_r, act_nxt;

  logic [MAX_PATTERN-1:0] pos_live;   // position lies inside the pattern
  logic [MAX_PATTERN-1:0] pos_star;   // live position holding '*'
  logic [MAX_PATTERN-1:0] pos_hit;    // live non-star position accepts the byte
  logic [MAX_PATTERN:0]   star_gen;
  logic [MAX_PATTERN:0]   star_prop;
  logic [MAX_PATTERN:0]   star_sum;
  logic [MAX_PATTERN:0]   closed;
  logic [MAX_PATTERN:0]   stepped;
  logic                   full;

  // Classify every stored byte against the current length and subject byte
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    assign pos_live[i] = (len_r > LEN_W'(i));
    assign pos_star[i] = pos_live[i] && (store_r[i] == CH_ANY_RUN);
    assign pos_hit[i]  = pos_live[i] && (store_r[i] != CH_ANY_RUN) &&
                         ((store_r[i] == CH_ANY_ONE) ? (step.character != CH_DOT)
                                                     : (step.character == store_r[i]));

    // Write the appended byte into its slot
    always_ff @(posedge clk) begin
      if (step.en && step.cmd == CMD_APPEND && len_r == LEN_W'(i)) begin
        store_r[i] <= step.character;
      end
    end
  end

  // Close the set across runs of '*': carries of (gen + prop) reach every
  // position that follows an active star through consecutive stars
  assign star_gen  = {1'b0, act_r[MAX_PATTERN-1:0] & pos_star};
  assign star_prop = {1'b0, pos_star};
  assign star_sum  = star_gen + star_prop;
  assign closed    = act_r | (star_sum ^ star_gen ^ star_prop);

  // Advance one subject byte: stars hold, matching positions move on
  assign stepped = {1'b0, closed[MAX_PATTERN-1:0] & pos_star} |
                   {closed[MAX_PATTERN-1:0] & pos_hit, 1'b0};

  assign full = (len_r == LEN_FULL);

  // Report the end-of-subject outcome from the present state
  assign result.matched          = closed[len_r] && !ovf_r;
  assign result.pattern_overflow = ovf_r;

  // Next state per command
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    act_nxt = act_r;
    if (step.en) begin
      case (step.cmd)
        CMD_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          act_nxt = ACT_INIT;
        end
        CMD_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
        CMD_SUBJECT: begin
          act_nxt = stepped;
        end
        CMD_END: begin
          act_nxt = ACT_INIT;
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      act_r <= ACT_INIT;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      act_r <= act_nxt;
    end
  end

  // Length never passes the store capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("pattern length beyond capacity");

  // Overflow can only be flagged with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flagged with store not full");

  // Clear restarts the length, the overflow flag and the position set
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step.en && step.cmd == CMD_CLEAR) |=> (len_r == '0 && !ovf_r && act_r == ACT_INIT))
    else $error("clear did not restart state");

  // End of subject restarts the position set
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step.en && step.cmd == CMD_END) |=> (act_r == ACT_INIT))
    else $error("position set not restarted after end of subject");

endmodule

/* hdl/wildcard_pattern_matcher_unit.sv */
// An end-of-subject word reaches out_tvalid through the input register, then the
// result register; a blocked result ahead of it can hold it in the input register.
// Throughput: one word per cycle; the position-set update (parallel byte
// compares plus one carry-chain add for star closure) is combinational.
// Input stalls only while an end-of-subject word waits behind an untaken result.
// Reset (rst_n low, synchronous): empty pattern, no overflow, position zero.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit: stream wrapper of the wildcard matcher
// Registers each command word, applies it to the matcher core and holds
// end-of-subject results in an output register until taken.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_unit #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wpm_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  cmd_e_t      s1_cmd_r;
  logic [7:0]  s1_char_r;
  logic        s1_fire;
  logic        in_take;

  logic        out_valid_r, out_valid_nxt;
  wpm_result_t out_data_r;

  wpm_step_t   core_step;
  wpm_result_t core_result;

  // Advance the held word unless its result has nowhere to go
  assign s1_fire = s1_valid_r &&
                   (s1_cmd_r != CMD_END || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_take   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= cmd_e_t'(in_tuser);
      s1_char_r <= in_tdata;
    end
  end

  assign core_step.en        = s1_fire;
  assign core_step.cmd       = s1_cmd_r;
  assign core_step.character = s1_char_r;

  wpm_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (core_step),
    .result (core_result)
  );

  // Load a result on end of subject, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_cmd_r == CMD_END) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd_r == CMD_END) begin
      out_data_r <= core_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r.pattern_overflow, out_data_r.matched};

  // An end-of-subject word that advances always leaves a result behind
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r == CMD_END) |=> out_tvalid)
    else $error("end of subject produced no result");

  // A reported overflow never comes with a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported together with overflow");

  // Input stalls only while a word is held and blocked
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_cmd_r == CMD_END && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for wildcard_pattern_matcher_unit
// Loads wildcard patterns and streams subject bytes and end-of-subject words
// through the block. A position-set predictor tracks the same pattern and
// compares every returned match word. Both stream sides stall at random, and
// one long output hold backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import wpm_pkg::*;

  localparam int CAP = MAX_PATTERN_DEF;

  // Pattern store, active positions and the match words still owed
  class glob_ledger;
    logic [7:0]   pat_bytes [CAP];
    int unsigned  pat_len;
    bit           dropped;
    bit [CAP:0]   live;
    wpm_result_t  owed_reports [$];
    int unsigned  bad_reports;

    function new();
      pat_len     = 0;
      dropped     = 1'b0;
      live        = {{CAP{1'b0}}, 1'b1};
      bad_reports = 0;
    endfunction

    // Extend the live set across runs of '*'
    function bit [CAP:0] closed();
      bit [CAP:0] d;
      int i;
      d = live;
      for (i = 0; i < pat_len; i++)
        if (d[i] && pat_bytes[i] == CH_ANY_RUN) d[i+1] = 1'b1;
      return d;
    endfunction

    // Move the live set forward by one subject byte
    function void advance(logic [7:0] c);
      bit [CAP:0] cur;
      bit [CAP:0] nxt;
      int i;
      cur = closed();
      nxt = '0;
      for (i = 0; i < pat_len; i++) begin
        if (cur[i]) begin
          if (pat_bytes[i] == CH_ANY_RUN)
            nxt[i] = 1'b1;
          else if (pat_bytes[i] == CH_ANY_ONE ? (c != CH_DOT) : (c == pat_bytes[i]))
            nxt[i+1] = 1'b1;
        end
      end
      live = nxt;
    endfunction

    // Apply one accepted input word
    function void note_word(cmd_e_t cmd, logic [7:0] c);
      wpm_result_t r;
      bit [CAP:0] fin;
      case (cmd)
        CMD_CLEAR: begin
          pat_len = 0;
          dropped = 1'b0;
          live    = {{CAP{1'b0}}, 1'b1};
        end
        CMD_APPEND: begin
          if (pat_len < CAP) begin
            pat_bytes[pat_len] = c;
            pat_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_SUBJECT: advance(c);
        CMD_END: begin
          fin = closed();
          r.matched          = fin[pat_len] && !dropped;
          r.pattern_overflow = dropped;
          owed_reports.push_back(r);
          live = {{CAP{1'b0}}, 1'b1};
        end
        default: begin
          live = live;
        end
      endcase
    endfunction

    // Compare one returned word against the oldest owed report
    function void check_report(logic [7:0] data);
      wpm_result_t want;
      if (owed_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("[%0t] unexpected result word %h", $realtime, data);
        return;
      end
      want = owed_reports.pop_front();
      if (data[0] !== want.matched || data[1] !== want.pattern_overflow ||
          data[7:2] !== 6'd0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("[%0t] mismatch: matched exp %b got %b, overflow exp %b got %b, pad %h",
                   $realtime, want.matched, data[0], want.pattern_overflow, data[1],
                   data[7:2]);
      end
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic [1:0] in_tuser   = 2'd0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  bit          idle_on   = 1'b1;
  bit          hold_req  = 1'b0;
  int          rx_hold   = 0;
  int unsigned words_sent = 0;

  glob_ledger book = new();

  wildcard_pattern_matcher_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check taken words and drive out_tready: bursts of stall, one long hold
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_report(out_tdata);
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   <= 1'b0;
      rx_hold    <= 300;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_hold    <= $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word, with an optional idle burst first; return at acceptance
  task automatic send_word(cmd_e_t cmd, logic [7:0] ch);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    book.note_word(cmd, ch);
    words_sent++;
  endtask

  // Stop offering and wait until every owed report is back
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1:    return CH_ANY_RUN;
      2:       return CH_ANY_ONE;
      3:       return CH_DOT;
      4, 5:    return "a";
      6:       return "b";
      7:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0, 1:    return "a";
      2:       return "b";
      3:       return CH_DOT;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0]  pat_q [$];
    logic [7:0]  subj_q [$];
    logic [7:0]  k;
    int          n;
    int unsigned first_rand;
    int unsigned done;
    bit          held;

    held = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern against empty and non-empty subjects
    send_word(CMD_END, 8'hFF);
    send_word(CMD_SUBJECT, "a");
    send_word(CMD_END, 8'h00);
    // Star-only pattern: empty subject, then dot and zero byte
    send_word(CMD_APPEND, CH_ANY_RUN);
    send_word(CMD_END, 8'h00);
    send_word(CMD_SUBJECT, CH_DOT);
    send_word(CMD_SUBJECT, 8'h00);
    send_word(CMD_END, 8'hFF);
    // Single-byte wildcard refuses a dot, takes anything else
    send_word(CMD_CLEAR, 8'hFF);
    send_word(CMD_APPEND, CH_ANY_ONE);
    send_word(CMD_SUBJECT, CH_DOT);
    send_word(CMD_END, 8'h00);
    send_word(CMD_SUBJECT, 8'hFF);
    send_word(CMD_END, 8'h00);
    // Zero byte is an ordinary literal
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_SUBJECT, 8'h00);
    send_word(CMD_END, 8'h00);
    // Pattern grows while a subject is in flight
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, "a");
    send_word(CMD_SUBJECT, "a");
    send_word(CMD_APPEND, "b");
    send_word(CMD_SUBJECT, "b");
    send_word(CMD_END, 8'h00);
    drain_reports();

    // Random patterns with mostly matching subjects, some noise
    first_rand = words_sent;
    while (words_sent - first_rand < 650) begin
      done = words_sent - first_rand;
      idle_on <= (done < 560) && !(done >= 200 && done < 280);
      if (!held && done >= 350) begin
        // Hold the output long while words keep coming
        held = 1'b1;
        drain_reports();
        hold_req <= 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(cmd_e_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        pat_q.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 8);
        repeat (n) pat_q.push_back(pick_pattern_byte());
        send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
        foreach (pat_q[i]) send_word(CMD_APPEND, pat_q[i]);
        repeat ($urandom_range(1, 4)) begin
          subj_q.delete();
          if ($urandom_range(0, 2) != 0) begin
            // Build a subject the pattern accepts, then maybe spoil one byte
            foreach (pat_q[i]) begin
              if (pat_q[i] == CH_ANY_RUN) begin
                repeat ($urandom_range(0, 3)) subj_q.push_back(pick_text_byte());
              end else if (pat_q[i] == CH_ANY_ONE) begin
                k = pick_text_byte();
                subj_q.push_back(k == CH_DOT ? 8'h78 : k);
              end else begin
                subj_q.push_back(pat_q[i]);
              end
            end
            if ($urandom_range(0, 3) == 0 && subj_q.size() > 0)
              subj_q[$urandom_range(0, subj_q.size() - 1)] = pick_text_byte();
          end else begin
            repeat ($urandom_range(0, 6)) subj_q.push_back(pick_text_byte());
          end
          foreach (subj_q[i]) begin
            if ($urandom_range(0, 19) == 0) begin
              k = pick_pattern_byte();
              pat_q.push_back(k);
              send_word(CMD_APPEND, k);
            end
            send_word(CMD_SUBJECT, subj_q[i]);
          end
          send_word(CMD_END, 8'($urandom_range(0, 255)));
        end
      end
    end

    drain_reports();
    repeat (8) @(posedge clk);
    if (book.bad_reports == 0 && book.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
